// ===== rtl/core/spl_pkg.sv =====
// shared constants, codes and types of the shuffled playlist sequencer
package spl_pkg;

  localparam int MAX_FILES = 64;
  localparam int ADDR_W    = $clog2(MAX_FILES);
  localparam int ORDER_W   = 8;
  localparam int DIV_W     = ADDR_W + 1;
  localparam int RW_W      = 31;
  localparam int DCNT_W    = $clog2(RW_W);
  localparam int VOL_W     = 5;
  localparam int VOL_MIN   = 1;
  localparam int VOL_MAX   = 30;
  localparam int RADIO_BIT = 7;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 24;

  typedef logic [2:0] kind_t;
  localparam kind_t K_START  = 3'd0;
  localparam kind_t K_RAND   = 3'd1;
  localparam kind_t K_POLL   = 3'd2;
  localparam kind_t K_STOP   = 3'd3;
  localparam kind_t K_TOGGLE = 3'd4;
  localparam kind_t K_VOLUME = 3'd5;

  typedef logic [2:0] action_t;
  localparam action_t A_PAUSE   = 3'd0;
  localparam action_t A_PLAY    = 3'd1;
  localparam action_t A_PVOL    = 3'd2;
  localparam action_t A_MUTE    = 3'd3;
  localparam action_t A_STATION = 3'd4;
  localparam action_t A_RVOL    = 3'd5;

  typedef logic [2:0] rsel_t;
  localparam rsel_t R_PAUSE    = 3'd0;
  localparam rsel_t R_MUTE_ON  = 3'd1;
  localparam rsel_t R_MUTE_OFF = 3'd2;
  localparam rsel_t R_STATION  = 3'd3;
  localparam rsel_t R_VOL      = 3'd4;
  localparam rsel_t R_RVOL     = 3'd5;
  localparam rsel_t R_PLAY     = 3'd6;

  typedef logic [2:0] ramop_t;
  localparam ramop_t RAM_NONE = 3'd0;
  localparam ramop_t RAM_FILL = 3'd1;
  localparam ramop_t RAM_RD_I = 3'd2;
  localparam ramop_t RAM_RD_J = 3'd3;
  localparam ramop_t RAM_RD_P = 3'd4;
  localparam ramop_t RAM_WR_I = 3'd5;
  localparam ramop_t RAM_WR_J = 3'd6;

  typedef struct packed {
    logic [15:0]       fm_station;
    logic signed [7:0] volume_request;
    logic              song_ended;
    logic [RW_W-1:0]   random_word;
    logic [7:0]        num_files;
    logic [7:0]        folder;
  } in_data_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic        playing;
    logic [15:0] argument;
  } out_data_t;

  typedef struct packed {
    logic   load;
    logic   do_begin;
    logic   play_set;
    logic   play_clr;
    logic   div_start;
    ramop_t ram_op;
    logic   pos_adv;
    logic   swap_dec;
    logic   out_load;
    rsel_t  out_sel;
    logic   out_last;
  } cmd_t;

  typedef struct packed {
    logic playing;
    logic radio_req;
    logic swap_pending;
    logic poll_ok;
    logic fill_last;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/spl_ram.sv =====
// generic single-port ram with registered read
module spl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/core/spl_dp.sv =====
// datapath: state registers, play order table, remainder unit and result register
module spl_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [spl_pkg::IN_DATA_W-1:0]   in_tdata,
  input  spl_pkg::cmd_t                   cmd,
  output spl_pkg::stat_t                  st,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [spl_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [2:0]                      out_tuser,
  output logic                            out_tlast
);

  spl_pkg::in_data_t in_d;
  spl_pkg::in_data_t item_r;

  logic       playing_r, playing_nxt;
  logic       radio_r, radio_nxt;
  logic [7:0] folder_r, folder_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] swap_r, swap_nxt;
  logic [7:0] clamp_cnt;
  logic [7:0] pos_inc;

  logic [spl_pkg::ADDR_W-1:0]  fill_r, fill_nxt;
  logic [spl_pkg::ORDER_W-1:0] tmp_r;

  logic [spl_pkg::RW_W-1:0]   dvd_r, dvd_nxt;
  logic [spl_pkg::DIV_W-1:0]  rem_r, rem_nxt;
  logic [spl_pkg::DIV_W-1:0]  dsr_r, dsr_nxt;
  logic [spl_pkg::DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic                       dbusy_r, dbusy_nxt;
  logic [spl_pkg::DIV_W:0]    rem_sh;

  logic                        ram_we, ram_re;
  logic [spl_pkg::ADDR_W-1:0]  ram_addr;
  logic [spl_pkg::ORDER_W-1:0] ram_wdata, ram_rdata;
  logic [spl_pkg::ADDR_W-1:0]  idx_i, idx_j;

  logic signed [7:0]          vreq;
  logic [spl_pkg::VOL_W-1:0]  vol;

  logic                 ovalid_r, ovalid_nxt;
  spl_pkg::out_data_t   odata_r, odata_nxt;
  logic [2:0]           ouser_r, ouser_nxt;
  logic                 olast_r, olast_nxt;

  assign in_d = spl_pkg::in_data_t'(in_tdata);

  assign clamp_cnt = (in_d.num_files > 8'(spl_pkg::MAX_FILES)) ?
                     8'(spl_pkg::MAX_FILES) : in_d.num_files;
  assign pos_inc   = pos_r + 8'd1;
  assign idx_i     = swap_r[spl_pkg::ADDR_W-1:0];
  assign idx_j     = rem_r[spl_pkg::ADDR_W-1:0];

  // control state
  always_comb begin
    playing_nxt = playing_r;
    radio_nxt   = radio_r;
    folder_nxt  = folder_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    swap_nxt    = swap_r;
    fill_nxt    = fill_r;
    if (cmd.play_set) begin
      playing_nxt = 1'b1;
    end else if (cmd.play_clr) begin
      playing_nxt = 1'b0;
    end
    if (cmd.do_begin) begin
      fill_nxt = '0;
      if (in_d.folder[spl_pkg::RADIO_BIT]) begin
        radio_nxt = 1'b1;
      end else begin
        radio_nxt  = 1'b0;
        folder_nxt = in_d.folder;
        count_nxt  = clamp_cnt;
        pos_nxt    = 8'd0;
        swap_nxt   = (clamp_cnt != 8'd0) ? clamp_cnt - 8'd1 : 8'd0;
      end
    end
    if (cmd.ram_op == spl_pkg::RAM_FILL) begin
      fill_nxt = fill_r + spl_pkg::ADDR_W'(1);
    end
    if (cmd.pos_adv) begin
      pos_nxt = (pos_inc >= count_r) ? 8'd0 : pos_inc;
    end
    if (cmd.swap_dec) begin
      swap_nxt = swap_r - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= 1'b0;
      radio_r   <= 1'b0;
      folder_r  <= 8'd1;
      count_r   <= 8'(spl_pkg::MAX_FILES);
      pos_r     <= 8'd0;
      swap_r    <= 8'd0;
      fill_r    <= '0;
    end else begin
      playing_r <= playing_nxt;
      radio_r   <= radio_nxt;
      folder_r  <= folder_nxt;
      count_r   <= count_nxt;
      pos_r     <= pos_nxt;
      swap_r    <= swap_nxt;
      fill_r    <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_d;
    end
    if (cmd.ram_op == spl_pkg::RAM_RD_J) begin
      tmp_r <= ram_rdata;
    end
  end

  // restoring remainder, one dividend bit per cycle
  assign rem_sh = {rem_r, dvd_r[spl_pkg::RW_W-1]};

  always_comb begin
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    dsr_nxt   = dsr_r;
    dcnt_nxt  = dcnt_r;
    dbusy_nxt = dbusy_r;
    if (cmd.div_start) begin
      dvd_nxt   = in_d.random_word;
      rem_nxt   = '0;
      dsr_nxt   = spl_pkg::DIV_W'(swap_r) + spl_pkg::DIV_W'(1);
      dcnt_nxt  = '0;
      dbusy_nxt = 1'b1;
    end else if (dbusy_r) begin
      dvd_nxt  = {dvd_r[spl_pkg::RW_W-2:0], 1'b0};
      rem_nxt  = (rem_sh >= {1'b0, dsr_r}) ? spl_pkg::DIV_W'(rem_sh - {1'b0, dsr_r}) :
                 spl_pkg::DIV_W'(rem_sh);
      dcnt_nxt = dcnt_r + spl_pkg::DCNT_W'(1);
      if (dcnt_r == spl_pkg::DCNT_W'(spl_pkg::RW_W - 1)) begin
        dbusy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else begin
      dbusy_r <= dbusy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    dcnt_r <= dcnt_nxt;
  end

  // play order table port
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = idx_i;
    ram_wdata = ram_rdata;
    case (cmd.ram_op)
      spl_pkg::RAM_FILL: begin
        ram_we    = 1'b1;
        ram_addr  = fill_r;
        ram_wdata = spl_pkg::ORDER_W'(fill_r) + spl_pkg::ORDER_W'(1);
      end
      spl_pkg::RAM_RD_I: begin
        ram_re = 1'b1;
      end
      spl_pkg::RAM_RD_J: begin
        ram_re   = 1'b1;
        ram_addr = idx_j;
      end
      spl_pkg::RAM_RD_P: begin
        ram_re   = 1'b1;
        ram_addr = pos_r[spl_pkg::ADDR_W-1:0];
      end
      spl_pkg::RAM_WR_I: begin
        ram_we = 1'b1;
      end
      spl_pkg::RAM_WR_J: begin
        ram_we    = 1'b1;
        ram_addr  = idx_j;
        ram_wdata = tmp_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  spl_ram #(
    .WIDTH (spl_pkg::ORDER_W),
    .DEPTH (spl_pkg::MAX_FILES)
  ) u_order (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // volume clamp
  assign vreq = item_r.volume_request;
  assign vol  = (vreq < 8'sd1)  ? spl_pkg::VOL_W'(spl_pkg::VOL_MIN) :
                (vreq > 8'sd30) ? spl_pkg::VOL_W'(spl_pkg::VOL_MAX) :
                spl_pkg::VOL_W'(vreq);

  // result register
  always_comb begin
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    ouser_nxt  = ouser_r;
    olast_nxt  = olast_r;
    if (cmd.out_load) begin
      ovalid_nxt        = 1'b1;
      olast_nxt         = cmd.out_last;
      odata_nxt.pad     = '0;
      odata_nxt.playing = playing_r;
      case (cmd.out_sel)
        spl_pkg::R_PAUSE: begin
          ouser_nxt          = spl_pkg::A_PAUSE;
          odata_nxt.argument = 16'd0;
        end
        spl_pkg::R_MUTE_ON: begin
          ouser_nxt          = spl_pkg::A_MUTE;
          odata_nxt.argument = 16'd1;
        end
        spl_pkg::R_MUTE_OFF: begin
          ouser_nxt          = spl_pkg::A_MUTE;
          odata_nxt.argument = 16'd0;
        end
        spl_pkg::R_STATION: begin
          ouser_nxt          = spl_pkg::A_STATION;
          odata_nxt.argument = item_r.fm_station;
        end
        spl_pkg::R_VOL: begin
          ouser_nxt          = spl_pkg::A_PVOL;
          odata_nxt.argument = 16'(vol);
        end
        spl_pkg::R_RVOL: begin
          ouser_nxt          = spl_pkg::A_RVOL;
          odata_nxt.argument = 16'(vol >> 1);
        end
        spl_pkg::R_PLAY: begin
          ouser_nxt          = spl_pkg::A_PLAY;
          odata_nxt.argument = {folder_r, ram_rdata};
        end
        default: begin
          ouser_nxt          = spl_pkg::A_PAUSE;
          odata_nxt.argument = 16'd0;
        end
      endcase
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

  // status
  assign st.playing      = playing_r;
  assign st.radio_req    = in_d.folder[spl_pkg::RADIO_BIT];
  assign st.swap_pending = (swap_r != 8'd0) && (swap_r < 8'(spl_pkg::MAX_FILES));
  assign st.poll_ok      = playing_r && !radio_r && in_d.song_ended &&
                           (count_r != 8'd0) && (pos_r < 8'(spl_pkg::MAX_FILES));
  assign st.fill_last    = (fill_r == spl_pkg::ADDR_W'(spl_pkg::MAX_FILES - 1));
  assign st.div_busy     = dbusy_r;
  assign st.out_free     = !ovalid_r || out_tready;

endmodule

// ===== rtl/core/spl_ctrl.sv =====
// controller: sequences fill, swap, poll and command emission
module spl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic [2:0]     in_tuser,
  output logic           in_tready,
  input  spl_pkg::stat_t st,
  output spl_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RD_J = 3'd3;
  localparam logic [2:0] S_WR_I = 3'd4;
  localparam logic [2:0] S_WR_J = 3'd5;
  localparam logic [2:0] S_POLL = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0]     state_r, state_nxt;
  spl_pkg::rsel_t sel_r, sel_nxt;
  logic           halt_r, halt_nxt;
  logic           radio_r, radio_nxt;
  logic           is_last;
  spl_pkg::rsel_t sel_next;
  logic           go_begin, go_halt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    is_last  = 1'b0;
    sel_next = spl_pkg::R_PAUSE;
    case (sel_r)
      spl_pkg::R_PAUSE:    sel_next = spl_pkg::R_MUTE_ON;
      spl_pkg::R_MUTE_ON: begin
        is_last  = halt_r;
        sel_next = radio_r ? spl_pkg::R_MUTE_OFF : spl_pkg::R_VOL;
      end
      spl_pkg::R_MUTE_OFF: sel_next = spl_pkg::R_STATION;
      spl_pkg::R_STATION:  sel_next = spl_pkg::R_VOL;
      spl_pkg::R_VOL:      sel_next = spl_pkg::R_RVOL;
      spl_pkg::R_RVOL:     is_last = 1'b1;
      spl_pkg::R_PLAY:     is_last = 1'b1;
      default:             is_last = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    halt_nxt  = halt_r;
    radio_nxt = radio_r;
    cmd       = '0;
    cmd.ram_op  = spl_pkg::RAM_NONE;
    cmd.out_sel = sel_r;
    cmd.out_last = is_last;
    go_begin  = 1'b0;
    go_halt   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          case (in_tuser)
            spl_pkg::K_START:  go_begin = 1'b1;
            spl_pkg::K_RAND: begin
              if (st.swap_pending) begin
                cmd.div_start = 1'b1;
                state_nxt     = S_DIV;
              end
            end
            spl_pkg::K_POLL: begin
              if (st.poll_ok) begin
                state_nxt = S_POLL;
              end
            end
            spl_pkg::K_STOP:   go_halt = 1'b1;
            spl_pkg::K_TOGGLE: begin
              go_halt  = st.playing;
              go_begin = !st.playing;
            end
            spl_pkg::K_VOLUME: begin
              if (st.playing) begin
                halt_nxt  = 1'b0;
                sel_nxt   = spl_pkg::R_VOL;
                state_nxt = S_EMIT;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
          if (go_begin) begin
            cmd.do_begin = 1'b1;
            cmd.play_set = 1'b1;
            halt_nxt     = 1'b0;
            radio_nxt    = st.radio_req;
            sel_nxt      = spl_pkg::R_PAUSE;
            state_nxt    = st.radio_req ? S_EMIT : S_FILL;
          end
          if (go_halt) begin
            cmd.play_clr = 1'b1;
            halt_nxt     = 1'b1;
            sel_nxt      = spl_pkg::R_PAUSE;
            state_nxt    = S_EMIT;
          end
        end
      end
      S_FILL: begin
        cmd.ram_op = spl_pkg::RAM_FILL;
        if (st.fill_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_DIV: begin
        if (!st.div_busy) begin
          cmd.ram_op = spl_pkg::RAM_RD_I;
          state_nxt  = S_RD_J;
        end
      end
      S_RD_J: begin
        cmd.ram_op = spl_pkg::RAM_RD_J;
        state_nxt  = S_WR_I;
      end
      S_WR_I: begin
        cmd.ram_op = spl_pkg::RAM_WR_I;
        state_nxt  = S_WR_J;
      end
      S_WR_J: begin
        cmd.ram_op   = spl_pkg::RAM_WR_J;
        cmd.swap_dec = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_POLL: begin
        cmd.ram_op  = spl_pkg::RAM_RD_P;
        cmd.pos_adv = 1'b1;
        sel_nxt     = spl_pkg::R_PLAY;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            sel_nxt = sel_next;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= spl_pkg::R_PAUSE;
      halt_r  <= 1'b0;
      radio_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      halt_r  <= halt_nxt;
      radio_r <= radio_nxt;
    end
  end

endmodule

// ===== rtl/core/shuffled_playlist_sequencer.sv =====
// top level of the shuffled playlist sequencer
// Takes one control transaction at a time and answers with up to six player and
// radio command transactions, one per cycle while the output side accepts them.
// A folder start rewrites the 64-entry play order table, one entry per cycle
// through its single port, before its commands go out; a radio start skips the
// fill. A random word, while swaps are pending, runs a bit-serial remainder
// unit over its 31 bits and then swaps two table entries: it reads both
// through the port and writes each back to the other's place. A song-end poll
// reads the table and plays the next file; a toggle while stopped runs as a
// start. A new transaction is taken as soon as the last command of the
// previous one sits in the output register.
module shuffled_playlist_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // folder, num_files, random_word, song_ended, volume_request, fm_station
  input  logic [spl_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic [2:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // argument, playing, zero pad
  output logic [spl_pkg::OUT_DATA_W-1:0] out_tdata,
  // action
  output logic [2:0]                     out_tuser,
  output logic                           out_tlast
);

  spl_pkg::cmd_t  cmd;
  spl_pkg::stat_t st;

  spl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  spl_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
